>>> rtl/eslp_pkg.sv
// Package for the event-stream line parser: character codes, field kinds,
// queue command and result types, and the keyword tables. No dependencies.
`default_nettype none

package eslp_pkg;

    localparam int NAME_MAX    = 32;
    localparam int NAME_ADDR_W = $clog2(NAME_MAX);
    localparam int NAME_LEN_W  = $clog2(NAME_MAX + 1);

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [2:0] {
        KIND_DATA  = 3'd0,
        KIND_EVENT = 3'd1,
        KIND_NAME  = 3'd2,
        KIND_VALUE = 3'd3,
        KIND_END   = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        CLS_DATA  = 2'd0,
        CLS_EVENT = 2'd1,
        CLS_OTHER = 2'd2
    } t_class;

    typedef enum logic {
        OP_EMIT   = 1'b0,
        OP_REPLAY = 1'b1
    } t_op;

    // One command from the front to the back. An emit command is one result
    // item; a replay command plays the held name and then the value byte.
    typedef struct packed {
        t_op                   op;
        t_kind                 kind;
        logic [7:0]            data;
        logic                  first;
        logic                  cut;
        logic [NAME_LEN_W-1:0] len;
    } t_cmd;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic       first;
        logic       cut;
        logic       last;
    } t_result;

    typedef struct packed {
        logic                   we;
        logic [NAME_ADDR_W-1:0] addr;
        logic [7:0]             data;
    } t_name_wr;

    function automatic logic [7:0] word_data(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h64;
            3'd1:    c = 8'h61;
            3'd2:    c = 8'h74;
            3'd3:    c = 8'h61;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] word_event(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h65;
            3'd1:    c = 8'h76;
            3'd2:    c = 8'h65;
            3'd3:    c = 8'h6E;
            3'd4:    c = 8'h74;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

>>> rtl/eslp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module eslp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> rtl/eslp_front.sv
// Front of the event-stream line parser: line and field tracking, name
// capture into the name RAM, classification. Depends on eslp_pkg.
`default_nettype none

module eslp_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [7:0]        i_byte,
    output logic                   o_ready,
    input  wire logic              i_q_full,
    input  wire logic              i_replay_done,
    output logic                   o_push,
    output eslp_pkg::t_cmd         o_cmd,
    output eslp_pkg::t_name_wr     o_name_wr
);

    typedef enum logic [4:0] {
        PH_NAME   = 5'b00001,
        PH_COLON  = 5'b00010,
        PH_SPACED = 5'b00100,
        PH_VALUE  = 5'b01000,
        PH_DROP   = 5'b10000
    } t_phase;

    localparam int LW = eslp_pkg::NAME_LEN_W;

    t_phase            r_phase, n_phase;
    logic              r_after_break, n_after_break;
    logic              r_pending_cr, n_pending_cr;
    logic [LW-1:0]     r_len, n_len;
    logic              r_ovf, n_ovf;
    eslp_pkg::t_class  r_class, n_class;
    logic              r_data_ok, n_data_ok;
    logic              r_event_ok, n_event_ok;
    logic              r_hold, n_hold;

    logic              accept;
    logic              is_data;
    logic              is_event;

    assign o_ready  = !i_q_full && !r_hold;
    assign accept   = i_valid && o_ready;
    assign is_data  = !r_ovf && (r_len == LW'(4)) && r_data_ok;
    assign is_event = !r_ovf && (r_len == LW'(5)) && r_event_ok;

    always_comb begin
        n_phase       = r_phase;
        n_after_break = r_after_break;
        n_pending_cr  = r_pending_cr;
        n_len         = r_len;
        n_ovf         = r_ovf;
        n_class       = r_class;
        n_data_ok     = r_data_ok;
        n_event_ok    = r_event_ok;
        n_hold        = r_hold && !i_replay_done;
        o_push        = 1'b0;
        o_cmd         = '{op: eslp_pkg::OP_EMIT, kind: eslp_pkg::KIND_END, data: i_byte,
                          first: 1'b1, cut: 1'b0, len: r_len};
        o_name_wr     = '{we: 1'b0, addr: r_len[eslp_pkg::NAME_ADDR_W-1:0], data: i_byte};

        if (accept) begin
            priority if (i_byte == eslp_pkg::CH_LF && r_pending_cr) begin
                // The LF of a CRLF pair belongs to the CR before it.
                n_pending_cr = 1'b0;
            end else if (i_byte == eslp_pkg::CH_LF || i_byte == eslp_pkg::CH_CR) begin
                n_pending_cr = (i_byte == eslp_pkg::CH_CR);
                n_phase      = PH_NAME;
                n_len        = '0;
                n_ovf        = 1'b0;
                n_class      = eslp_pkg::CLS_DATA;
                n_data_ok    = 1'b1;
                n_event_ok   = 1'b1;
                if (r_after_break) begin
                    o_push        = 1'b1;
                    o_cmd.data    = 8'h00;
                    o_cmd.first   = 1'b0;
                    n_after_break = 1'b0;
                end else begin
                    n_after_break = 1'b1;
                end
            end else begin
                n_pending_cr  = 1'b0;
                n_after_break = 1'b0;
                unique case (r_phase)
                    PH_NAME: begin
                        if (i_byte == eslp_pkg::CH_COLON) begin
                            n_phase = (r_len == '0) ? PH_DROP : PH_COLON;
                        end else if (r_len < LW'(eslp_pkg::NAME_MAX)) begin
                            o_name_wr.we = 1'b1;
                            n_len        = r_len + LW'(1);
                            n_data_ok    = r_data_ok && (r_len < LW'(4))
                                           && (i_byte == eslp_pkg::word_data(r_len[2:0]));
                            n_event_ok   = r_event_ok && (r_len < LW'(5))
                                           && (i_byte == eslp_pkg::word_event(r_len[2:0]));
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end
                    PH_COLON, PH_SPACED: begin
                        if (r_phase == PH_COLON && i_byte == eslp_pkg::CH_SPACE) begin
                            n_phase = PH_SPACED;
                        end else begin
                            // First value byte: classify the field.
                            n_phase = PH_VALUE;
                            o_push  = 1'b1;
                            if (is_data) begin
                                n_class    = eslp_pkg::CLS_DATA;
                                o_cmd.kind = eslp_pkg::KIND_DATA;
                            end else if (is_event) begin
                                n_class    = eslp_pkg::CLS_EVENT;
                                o_cmd.kind = eslp_pkg::KIND_EVENT;
                            end else begin
                                n_class    = eslp_pkg::CLS_OTHER;
                                o_cmd.op   = eslp_pkg::OP_REPLAY;
                                o_cmd.kind = eslp_pkg::KIND_VALUE;
                                o_cmd.cut  = r_ovf;
                                n_hold     = 1'b1;
                            end
                        end
                    end
                    PH_VALUE: begin
                        o_push      = 1'b1;
                        o_cmd.first = 1'b0;
                        unique case (r_class)
                            eslp_pkg::CLS_DATA:  o_cmd.kind = eslp_pkg::KIND_DATA;
                            eslp_pkg::CLS_EVENT: o_cmd.kind = eslp_pkg::KIND_EVENT;
                            default: begin
                                o_cmd.kind = eslp_pkg::KIND_VALUE;
                                o_cmd.cut  = r_ovf;
                            end
                        endcase
                    end
                    PH_DROP: begin
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_NAME;
            r_after_break <= 1'b0;
            r_pending_cr  <= 1'b0;
            r_len         <= '0;
            r_ovf         <= 1'b0;
            r_class       <= eslp_pkg::CLS_DATA;
            r_data_ok     <= 1'b1;
            r_event_ok    <= 1'b1;
            r_hold        <= 1'b0;
        end else begin
            r_phase       <= n_phase;
            r_after_break <= n_after_break;
            r_pending_cr  <= n_pending_cr;
            r_len         <= n_len;
            r_ovf         <= n_ovf;
            r_class       <= n_class;
            r_data_ok     <= n_data_ok;
            r_event_ok    <= n_event_ok;
            r_hold        <= n_hold;
        end
    end

endmodule

`default_nettype wire

>>> rtl/eslp_fifo.sv
// Command queue between the parser front and back.
// Depends on eslp_pkg for the command type and depth.
`default_nettype none

module eslp_fifo (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  wire eslp_pkg::t_cmd i_cmd,
    input  wire logic     i_pop,
    output eslp_pkg::t_cmd o_head,
    output logic          o_empty,
    output logic          o_full
);

    localparam int PW = eslp_pkg::QUEUE_PTR_W;
    localparam int CW = eslp_pkg::QUEUE_CNT_W;

    eslp_pkg::t_cmd r_slot [eslp_pkg::QUEUE_DEPTH];
    logic [PW-1:0]  r_wr, n_wr;
    logic [PW-1:0]  r_rd, n_rd;
    logic [CW-1:0]  r_cnt, n_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CW'(eslp_pkg::QUEUE_DEPTH));
    assign o_head  = r_slot[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PW'(eslp_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr + PW'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PW'(eslp_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

>>> rtl/eslp_back.sv
// Back of the event-stream line parser: runs queued commands, replays held
// names from the name RAM, drives the output register. Depends on eslp_pkg.
`default_nettype none

module eslp_back (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire eslp_pkg::t_cmd                    i_head,
    input  wire logic                              i_empty,
    output logic                                   o_pop,
    output logic [eslp_pkg::NAME_ADDR_W-1:0]       o_raddr,
    input  wire logic [7:0]                        i_rdata,
    output logic                                   o_replay_done,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output eslp_pkg::t_result                      o_res
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_RD   = 4'b0010,
        ST_WR   = 4'b0100,
        ST_VAL  = 4'b1000
    } t_state;

    localparam int LW = eslp_pkg::NAME_LEN_W;

    t_state            r_state, n_state;
    logic [LW-1:0]     r_idx, n_idx;
    logic [LW-1:0]     r_len;
    logic              r_cut;
    logic [7:0]        r_byte;
    logic              r_valid, n_valid;
    eslp_pkg::t_result r_res, n_res;
    logic              out_free;
    logic              load;

    assign out_free = !r_valid || i_ready;
    assign o_raddr  = r_idx[eslp_pkg::NAME_ADDR_W-1:0];
    assign o_valid  = r_valid;
    assign o_res    = r_res;

    always_comb begin
        n_state       = r_state;
        n_idx         = r_idx;
        n_res         = r_res;
        load          = 1'b0;
        o_pop         = 1'b0;
        o_replay_done = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    if (i_head.op == eslp_pkg::OP_REPLAY) begin
                        o_pop   = 1'b1;
                        n_idx   = '0;
                        n_state = ST_RD;
                    end else if (out_free) begin
                        o_pop = 1'b1;
                        load  = 1'b1;
                        n_res = '{kind: i_head.kind, data: i_head.data, first: i_head.first,
                                  cut: i_head.cut, last: 1'b1};
                    end
                end
            end
            ST_RD: begin
                // Address is out; read data arrives next cycle.
                n_state = ST_WR;
            end
            ST_WR: begin
                if (out_free) begin
                    load    = 1'b1;
                    n_res   = '{kind: eslp_pkg::KIND_NAME, data: i_rdata,
                                first: (r_idx == '0), cut: r_cut, last: 1'b0};
                    n_idx   = r_idx + LW'(1);
                    n_state = (r_idx + LW'(1) == r_len) ? ST_VAL : ST_RD;
                end
            end
            ST_VAL: begin
                if (out_free) begin
                    load          = 1'b1;
                    n_res         = '{kind: eslp_pkg::KIND_VALUE, data: r_byte,
                                      first: 1'b1, cut: r_cut, last: 1'b1};
                    o_replay_done = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        n_valid = load ? 1'b1 : (r_valid && !i_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (r_state == ST_IDLE && o_pop) begin
            r_len  <= i_head.len;
            r_cut  <= i_head.cut;
            r_byte <= i_head.data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/event_stream_line_parser_unit.sv
// Top level of the event-stream line parser: front, command queue, name RAM
// and back. Depends on eslp_pkg, eslp_front, eslp_fifo, eslp_ram, eslp_back.
//
// Usage. Raw stream bytes enter on the slave stream (one byte per item in
// tdata). LF, CR and CRLF end a line; a second break in a row ends a message.
// Results leave on the master stream: tdata carries the byte, tuser carries
// the kind, a first-of-run flag and a name-truncated flag, and tlast marks
// the last result that one input byte causes. Bytes that cause no result
// (name bytes, the colon, the skipped space, dropped lines) just vanish.
// A byte that causes a single result is registered in the command queue and
// then in the output register. The front takes one byte per cycle while the
// four-entry command queue has room and no replay is under way, and the back
// emits one data, event or message-end result per cycle while the receiver
// takes them. A field that is neither data nor event starts its replay, then
// for each held name byte reads it from the name RAM and loads it into the
// output register, and then loads the value byte; the input stays stalled
// from that field's first value byte until the value byte is loaded.
// Reset (synchronous, active low) returns to the start of a line and of a
// message and empties the queue and output register; the name RAM is not
// cleared, as only entries written on the current line are ever read.
// When the receiver stalls, the output register holds its result, the back
// stops, the queue fills and then the input is held off.
`default_nettype none

module event_stream_line_parser_unit (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_axis_tvalid,
    output logic            o_s_axis_tready,
    input  wire logic [7:0] i_s_axis_tdata,   // [7:0] byte_in
    output logic            o_m_axis_tvalid,
    input  wire logic       i_m_axis_tready,
    output logic [7:0]      o_m_axis_tdata,   // [7:0] byte_out
    output logic [4:0]      o_m_axis_tuser,   // [2:0] kind, [3] field_first, [4] name_cut
    output logic            o_m_axis_tlast
);

    logic                               push;
    eslp_pkg::t_cmd                     cmd;
    eslp_pkg::t_cmd                     head;
    logic                               q_empty;
    logic                               q_full;
    logic                               pop;
    eslp_pkg::t_name_wr                 name_wr;
    logic [eslp_pkg::NAME_ADDR_W-1:0]   raddr;
    logic [7:0]                         rdata;
    logic                               replay_done;
    eslp_pkg::t_result                  res;

    // Front: classifies each byte and queues the commands for its results.
    eslp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_s_axis_tvalid),
        .i_byte        (i_s_axis_tdata),
        .o_ready       (o_s_axis_tready),
        .i_q_full      (q_full),
        .i_replay_done (replay_done),
        .o_push        (push),
        .o_cmd         (cmd),
        .o_name_wr     (name_wr)
    );

    eslp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // Name buffer: written by the front, read back by the back on replay.
    eslp_ram #(
        .WIDTH (8),
        .DEPTH (eslp_pkg::NAME_MAX)
    ) u_name_ram (
        .i_clk   (i_clk),
        .i_we    (name_wr.we),
        .i_waddr (name_wr.addr),
        .i_wdata (name_wr.data),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Back: turns commands into result items in the output register.
    eslp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .i_empty       (q_empty),
        .o_pop         (pop),
        .o_raddr       (raddr),
        .i_rdata       (rdata),
        .o_replay_done (replay_done),
        .o_valid       (o_m_axis_tvalid),
        .i_ready       (i_m_axis_tready),
        .o_res         (res)
    );

    assign o_m_axis_tdata = res.data;
    assign o_m_axis_tuser = {res.cut, res.first, res.kind};
    assign o_m_axis_tlast = res.last;

endmodule

`default_nettype wire

>>> tb/event_stream_line_parser_unit_tb.sv
// Self-checking testbench for the event-stream line parser unit.
// It keeps its own line parser model in a small scoreboard class and
// compares every result item with it; depends only on eslp_pkg and the RTL.
`default_nettype none

module event_stream_line_parser_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned QUIET_LIMIT  = 1000;
    localparam int unsigned RANDOM_BYTES = 120;
    localparam int unsigned DRAIN_CYCLES = 20;

    // Predicts the result items of each accepted stream byte and holds them
    // until the block delivers them.
    class line_parser_model;

        typedef enum {PH_NAME, PH_COLON, PH_SPACED, PH_VALUE, PH_DROP} t_phase;

        t_phase            phase;
        bit                after_break;
        bit                pending_cr;
        logic [7:0]        held[eslp_pkg::NAME_MAX];
        int unsigned       held_len;
        bit                cut;
        eslp_pkg::t_class  cls;
        eslp_pkg::t_result batch[$];
        eslp_pkg::t_result awaited[$];
        int unsigned       faults;

        function new();
            restart_line();
            after_break = 1'b0;
            pending_cr  = 1'b0;
            faults      = 0;
        endfunction

        function void restart_line();
            phase    = PH_NAME;
            held_len = 0;
            cut      = 1'b0;
            cls      = eslp_pkg::CLS_DATA;
        endfunction

        function void add(eslp_pkg::t_kind k, logic [7:0] b, bit first, bit c);
            eslp_pkg::t_result r;
            r.kind  = k;
            r.data  = b;
            r.first = first;
            r.cut   = c;
            r.last  = 1'b0;
            batch.push_back(r);
        endfunction

        // A name that was cut short never counts as a keyword.
        function bit name_matches(string word);
            if (cut || held_len != word.len())
                return 1'b0;
            for (int i = 0; i < word.len(); i++)
                if (held[i] != word[i])
                    return 1'b0;
            return 1'b1;
        endfunction

        function void begin_value(logic [7:0] b);
            if (name_matches("data")) begin
                cls = eslp_pkg::CLS_DATA;
                add(eslp_pkg::KIND_DATA, b, 1'b1, 1'b0);
            end else if (name_matches("event")) begin
                cls = eslp_pkg::CLS_EVENT;
                add(eslp_pkg::KIND_EVENT, b, 1'b1, 1'b0);
            end else begin
                // Other fields replay the kept name bytes ahead of the value.
                cls = eslp_pkg::CLS_OTHER;
                for (int i = 0; i < held_len; i++)
                    add(eslp_pkg::KIND_NAME, held[i], i == 0, cut);
                add(eslp_pkg::KIND_VALUE, b, 1'b1, cut);
            end
            phase = PH_VALUE;
        endfunction

        function void take_byte(logic [7:0] b);
            eslp_pkg::t_result tail;
            batch.delete();
            if (b == eslp_pkg::CH_LF && pending_cr) begin
                // The LF of a CRLF pair belongs to the CR.
                pending_cr = 1'b0;
                return;
            end
            if (b == eslp_pkg::CH_LF || b == eslp_pkg::CH_CR) begin
                pending_cr = (b == eslp_pkg::CH_CR);
                restart_line();
                if (after_break) begin
                    add(eslp_pkg::KIND_END, 8'h00, 1'b0, 1'b0);
                    after_break = 1'b0;
                end else begin
                    after_break = 1'b1;
                end
            end else begin
                pending_cr  = 1'b0;
                after_break = 1'b0;
                case (phase)
                    PH_NAME: begin
                        if (b == eslp_pkg::CH_COLON)
                            phase = (held_len == 0) ? PH_DROP : PH_COLON;
                        else if (held_len < eslp_pkg::NAME_MAX) begin
                            held[held_len] = b;
                            held_len++;
                        end else
                            cut = 1'b1;
                    end
                    PH_COLON: begin
                        if (b == eslp_pkg::CH_SPACE)
                            phase = PH_SPACED;
                        else
                            begin_value(b);
                    end
                    PH_SPACED: begin_value(b);
                    PH_VALUE: begin
                        case (cls)
                            eslp_pkg::CLS_DATA:  add(eslp_pkg::KIND_DATA, b, 1'b0, 1'b0);
                            eslp_pkg::CLS_EVENT: add(eslp_pkg::KIND_EVENT, b, 1'b0, 1'b0);
                            default:             add(eslp_pkg::KIND_VALUE, b, 1'b0, cut);
                        endcase
                    end
                    default: ;
                endcase
            end
            if (batch.size() > 0) begin
                tail = batch.pop_back();
                tail.last = 1'b1;
                batch.push_back(tail);
                foreach (batch[i])
                    awaited.push_back(batch[i]);
            end
        endfunction

        function void check_field(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s mismatch: expected %0d, actual %0d", field, want, got);
                faults++;
            end
        endfunction

        function void match_result(eslp_pkg::t_result got);
            eslp_pkg::t_result want;
            if (awaited.size() == 0) begin
                $error("result item with none expected: kind %0d byte %0d",
                       got.kind, got.data);
                faults++;
                return;
            end
            want = awaited.pop_front();
            check_field("kind", want.kind, got.kind);
            check_field("byte_out", want.data, got.data);
            check_field("field_first", want.first, got.first);
            check_field("name_cut", want.cut, got.cut);
            check_field("last", want.last, got.last);
        endfunction

    endclass

    logic       clk     = 1'b0;
    logic       rst_n   = 1'b0;
    logic       s_valid = 1'b0;
    logic [7:0] s_data  = 8'h00;
    logic       m_ready = 1'b0;

    wire        o_s_axis_tready;
    wire        o_m_axis_tvalid;
    wire [7:0]  o_m_axis_tdata;   // [7:0] byte_out
    wire [4:0]  o_m_axis_tuser;   // [2:0] kind, [3] field_first, [4] name_cut
    wire        o_m_axis_tlast;

    line_parser_model  board;
    eslp_pkg::t_result seen;
    int unsigned       bytes_sent  = 0;
    int unsigned       random_goal = 0;
    int unsigned       burst_left  = 0;
    int unsigned       quiet_cycles = 0;
    int unsigned       stall_mode  = 0;
    int unsigned       stall_left  = 0;
    int unsigned       stall_phase = 0;

    event_stream_line_parser_unit dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Receiver: stretches of steady readiness, coin flips, one cycle in four,
    // and short full stalls, each lasting a random number of cycles.
    always @(posedge clk) begin
        if (stall_left == 0) begin
            stall_mode  = $urandom_range(0, 3);
            stall_left  = (stall_mode == 3) ? $urandom_range(2, 12) : $urandom_range(10, 60);
            stall_phase = 0;
        end
        stall_left--;
        stall_phase++;
        case (stall_mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= 1'($urandom_range(0, 1));
            2:       m_ready <= (stall_phase % 4 == 0);
            default: m_ready <= 1'b0;
        endcase
    end

    // Every result item the block hands over is checked against the model.
    always @(posedge clk) begin
        if (rst_n && o_m_axis_tvalid && m_ready) begin
            seen.kind  = eslp_pkg::t_kind'(o_m_axis_tuser[2:0]);
            seen.data  = o_m_axis_tdata;
            seen.first = o_m_axis_tuser[3];
            seen.cut   = o_m_axis_tuser[4];
            seen.last  = o_m_axis_tlast;
            board.match_result(seen);
        end
    end

    // A run in which neither side moves an item for too long has hung.
    always @(posedge clk) begin
        if (!rst_n || (s_valid && o_s_axis_tready) || (o_m_axis_tvalid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("event_stream_line_parser_unit_tb NOT OK");
            $finish;
        end
    end

    // Offers one byte, in bursts of random length with random gaps between.
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_valid <= 1'b1;
        s_data  <= b;
        do @(posedge clk); while (!o_s_axis_tready);
        board.take_byte(b);
        burst_left--;
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    function automatic logic [7:0] name_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (b == eslp_pkg::CH_COLON || b == eslp_pkg::CH_LF || b == eslp_pkg::CH_CR);
        return b;
    endfunction

    function automatic logic [7:0] value_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (b == eslp_pkg::CH_LF || b == eslp_pkg::CH_CR);
        return b;
    endfunction

    // Mostly short names, the keywords and near misses; line 2 always gets a
    // name past the buffer and line 5 one that fills it exactly.
    task automatic send_name(input int unsigned line_no);
        int unsigned len;
        len = 0;
        if (line_no == 2)
            len = eslp_pkg::NAME_MAX + 8;
        else if (line_no == 5)
            len = eslp_pkg::NAME_MAX;
        else begin
            case ($urandom_range(0, 7))
                0, 1:    send_text("data");
                2:       send_text("event");
                3:       send_text("dat");
                4:       send_text("events");
                5:       len = $urandom_range(eslp_pkg::NAME_MAX, eslp_pkg::NAME_MAX + 8);
                default: len = $urandom_range(1, 6);
            endcase
        end
        repeat (len) send_byte(name_byte());
    endtask

    // The first value byte is often a space or a colon, which are plain
    // value bytes in that position.
    task automatic send_value(input int unsigned n);
        logic [7:0] b;
        for (int i = 0; i < n; i++) begin
            b = value_byte();
            if (i == 0 && $urandom_range(0, 3) == 0)
                b = $urandom_range(0, 1) ? eslp_pkg::CH_SPACE : eslp_pkg::CH_COLON;
            send_byte(b);
        end
    endtask

    // LF, CR or CRLF, then maybe a second break, which ends the message if not CR-LF.
    task automatic end_line();
        case ($urandom_range(0, 2))
            0:       send_byte(eslp_pkg::CH_LF);
            1:       send_byte(eslp_pkg::CH_CR);
            default: begin
                send_byte(eslp_pkg::CH_CR);
                send_byte(eslp_pkg::CH_LF);
            end
        endcase
        if ($urandom_range(0, 3) == 0)
            send_byte($urandom_range(0, 1) ? eslp_pkg::CH_LF : eslp_pkg::CH_CR);
    endtask

    task automatic send_random_line(input int unsigned line_no);
        int unsigned shape;
        shape = $urandom_range(0, 9);
        if (line_no == 2 || line_no == 5)
            shape = 9;
        case (shape)
            0: repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
            1: begin
                send_byte(eslp_pkg::CH_COLON);
                send_value($urandom_range(0, 4));
                end_line();
            end
            2: begin
                send_name(line_no);
                end_line();
            end
            3: begin
                send_name(line_no);
                send_byte(eslp_pkg::CH_COLON);
                if ($urandom_range(0, 1))
                    send_byte(eslp_pkg::CH_SPACE);
                end_line();
            end
            default: begin
                send_name(line_no);
                send_byte(eslp_pkg::CH_COLON);
                if ($urandom_range(0, 1))
                    send_byte(eslp_pkg::CH_SPACE);
                send_value($urandom_range(1, 6));
                end_line();
            end
        endcase
    endtask

    initial begin
        int unsigned line_no;
        board = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Data line with the skipped space and the top byte value, then a
        // second LF that ends the message.
        send_text("data: ");
        send_byte(8'hFF);
        send_byte(eslp_pkg::CH_LF);
        send_byte(eslp_pkg::CH_LF);
        // Other field whose value starts with a second colon and holds the
        // zero byte; CRLF ends the line, a CR ends the message and the LF
        // after that CR is swallowed.
        send_text("x:: ");
        send_byte(8'h00);
        send_byte(eslp_pkg::CH_CR);
        send_byte(eslp_pkg::CH_LF);
        send_byte(eslp_pkg::CH_CR);
        send_byte(eslp_pkg::CH_LF);
        // Event field whose only value byte is the second space.
        send_text("event:  ");
        send_byte(eslp_pkg::CH_LF);
        // A comment line and a line with an empty value give nothing.
        send_text(":c");
        send_byte(eslp_pkg::CH_LF);
        send_text("q:");
        send_byte(eslp_pkg::CH_LF);

        random_goal = bytes_sent + RANDOM_BYTES;
        line_no = 0;
        while (bytes_sent < random_goal) begin
            send_random_line(line_no);
            line_no++;
        end
        s_valid <= 1'b0;

        while (board.awaited.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.faults == 0 && board.awaited.size() == 0)
            $display("event_stream_line_parser_unit_tb OK");
        else
            $display("event_stream_line_parser_unit_tb NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
